// ===== src/fac_pkg.sv =====
// Shared constants, types and functions of the fully associative tag store.
package fac_pkg;

    // Number of tag slots and derived index width.
    localparam int unsigned ENTRIES = 4;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);

    // Field widths of the streams.
    localparam int unsigned ADDR_W      = 31;
    localparam int unsigned SLOT_W      = 2;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_TUSER_W = 2;

    // Victim-choice LFSR.
    localparam int unsigned     LFSR_W     = 16;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'h0001;

    // Reciprocal of ENTRIES used to reduce the LFSR value to a slot number.
    localparam int unsigned       RECIP_SHIFT = 24;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / ENTRIES);

    // Priority chain passed from each cell to the next one.
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
    } fac_chain_t;

    // One step of the Galois LFSR: shift right, apply the mask when a one drops out.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_MASK;
        end
        return n;
    endfunction

    // A zero seed would lock the LFSR, so it loads as one.
    function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] s);
        return (s == '0) ? SEED_RESET : s;
    endfunction

endpackage

// ===== src/fac_cell.sv =====
// One tag slot of the store: tag, valid bit, compare and priority chain stage.
module fac_cell
    import fac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] lookup_addr,
    input  logic              wr_en,
    input  fac_chain_t        chain_in,
    output fac_chain_t        chain_out,
    output logic              hit_here,
    output logic              empty_here,
    output logic [ADDR_W-1:0] tag,
    output logic              valid
);

    logic [ADDR_W-1:0] tag_reg;
    logic [ADDR_W-1:0] tag_next;
    logic              valid_reg;
    logic              valid_next;
    logic              match;

    // Compare against the lookup address while the slot holds a tag.
    assign match = valid_reg && (tag_reg == lookup_addr);

    // This slot wins only if no lower slot already claimed the role.
    assign hit_here   = match && !chain_in.hit_seen;
    assign empty_here = !valid_reg && !chain_in.empty_seen;

    assign chain_out.hit_seen   = chain_in.hit_seen || match;
    assign chain_out.empty_seen = chain_in.empty_seen || !valid_reg;

    assign tag   = tag_reg;
    assign valid = valid_reg;

    // Next state: a write stores the lookup address and marks the slot valid.
    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (wr_en)
        begin
            tag_next   = lookup_addr;
            valid_next = 1'b1;
        end
    end

    // Valid bit is control state and clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Tag is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

// ===== src/fully_assoc_cache_random_replace_core.sv =====
// Top level of the fully associative tag store with LFSR-driven random replacement.
//
// Usage: each request on the s_ stream carries one 31-bit block address. The block
// looks it up in a row of tag cells and returns one result on the m_ stream: hit and
// evicted flags in m_tuser, the slot number and slot content in m_tdata. A miss fills
// the lowest empty slot; with all slots full a victim is picked by a 16-bit LFSR and
// its old address is returned.
// Sequencing: one request is handled at a time. A hit or a fill goes from S_CMP straight
// to the result register. A replacement passes through S_CMP (compare and LFSR step),
// S_MUL and S_REM (a reciprocal multiply that reduces the LFSR value to a slot number)
// and S_EVICT (the eviction) before its result is registered. A new request is accepted
// only in S_IDLE, once the result of the last one has been loaded.
// Configuration: a write on cfg_ loads the LFSR with the seed (zero loads as one);
// cfg_ready is always high and writes are meant only while the block is idle.
// Reset: all slots become empty and the LFSR loads one; no clearing pass is needed.
// Stall: the result register holds while m_tready is low; the next request may be
// accepted meanwhile, but it completes only once the register is free.
module fully_assoc_cache_random_replace_core
    import fac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream. s_tdata: block_address[30:0], zero fill above.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream. m_tdata: slot[1:0], slot_content[32:2], zero fill above.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: hit[0], evicted[1].
    output logic [OUT_TUSER_W-1:0] m_tuser,
    // Seed register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LFSR_W-1:0]      cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_MUL   = 5'b00100,
        S_REM   = 5'b01000,
        S_EVICT = 5'b10000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ADDR_W-1:0]             addr_reg;
    logic [ADDR_W-1:0]             addr_next;
    logic [LFSR_W-1:0]             lfsr_reg;
    logic [LFSR_W-1:0]             lfsr_next_val;
    logic [LFSR_W+RECIP_SHIFT-1:0] prod_reg;
    logic [LFSR_W+RECIP_SHIFT-1:0] prod_next;
    logic [IDX_W-1:0]              victim_reg;
    logic [IDX_W-1:0]              victim_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [OUT_TDATA_W-1:0]        out_data_reg;
    logic [OUT_TDATA_W-1:0]        out_data_next;
    logic [OUT_TUSER_W-1:0]        out_user_reg;
    logic [OUT_TUSER_W-1:0]        out_user_next;

    fac_chain_t                    chain [ENTRIES+1];
    logic [ENTRIES-1:0]            hit_vec;
    logic [ENTRIES-1:0]            empty_vec;
    logic [ENTRIES-1:0]            valid_vec;
    logic [ENTRIES-1:0]            cell_wr;
    logic [ADDR_W-1:0]             cell_tag [ENTRIES];

    logic                          s_accept;
    logic                          out_free;
    logic                          load_out;
    logic                          any_hit;
    logic                          any_empty;
    logic [IDX_W-1:0]              hit_idx;
    logic [IDX_W-1:0]              empty_idx;
    logic [IDX_W-1:0]              res_idx;
    logic                          res_hit;
    logic                          res_evicted;
    logic [ADDR_W-1:0]             res_content;
    logic [LFSR_W-1:0]             quot;
    logic [LFSR_W-1:0]             quot_times_n;
    logic [LFSR_W-1:0]             remd;

    // Handshakes.
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Row of tag cells linked by the priority chain.
    assign chain[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        fac_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .lookup_addr (addr_reg),
            .wr_en       (cell_wr[g]),
            .chain_in    (chain[g]),
            .chain_out   (chain[g+1]),
            .hit_here    (hit_vec[g]),
            .empty_here  (empty_vec[g]),
            .tag         (cell_tag[g]),
            .valid       (valid_vec[g])
        );
    end

    assign any_hit   = chain[ENTRIES].hit_seen;
    assign any_empty = chain[ENTRIES].empty_seen;

    // Encode the one-hot winner vectors into slot numbers.
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (empty_vec[i])
            begin
                empty_idx = empty_idx | IDX_W'(i);
            end
        end
    end

    // Reduce the LFSR value modulo ENTRIES: quotient from the registered product,
    // remainder with one correction step.
    assign quot         = prod_reg[LFSR_W+RECIP_SHIFT-1:RECIP_SHIFT];
    assign quot_times_n = LFSR_W'(quot * LFSR_W'(ENTRIES));
    always_comb
    begin
        remd = lfsr_reg - quot_times_n;
        if (remd >= LFSR_W'(ENTRIES))
        begin
            remd = remd - LFSR_W'(ENTRIES);
        end
    end

    // Sequencer, cell writes and result selection.
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        lfsr_next_val = lfsr_reg;
        prod_next     = prod_reg;
        victim_next   = victim_reg;
        cell_wr       = '0;
        load_out      = 1'b0;
        res_idx       = hit_idx;
        res_hit       = 1'b0;
        res_evicted   = 1'b0;
        res_content   = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    addr_next  = s_tdata[ADDR_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!any_hit && !any_empty)
                begin
                    lfsr_next_val = lfsr_next(lfsr_reg);
                    state_next    = S_MUL;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (any_hit)
                    begin
                        res_hit = 1'b1;
                        res_idx = hit_idx;
                    end
                    else
                    begin
                        res_idx = empty_idx;
                        cell_wr = empty_vec;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = lfsr_reg * RECIP;
                state_next = S_REM;
            end
            S_REM:
            begin
                victim_next = remd[IDX_W-1:0];
                state_next  = S_EVICT;
            end
            S_EVICT:
            begin
                res_idx     = victim_reg;
                res_evicted = 1'b1;
                res_content = cell_tag[victim_reg];
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        cell_wr[i] = (victim_reg == IDX_W'(i));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A seed write reloads the LFSR.
        if (cfg_valid && cfg_ready)
        begin
            lfsr_next_val = seed_load(cfg_data);
        end
    end

    // Result register: loads a new result or empties when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TDATA_W'({res_content, SLOT_W'(res_idx)});
            out_user_next  = {res_evicted, res_hit};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lfsr_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next_val;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        prod_reg     <= prod_next;
        victim_reg   <= victim_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // A replacement happens only when every slot holds a tag.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |-> (&valid_vec))
        else $error("replacement while an empty slot exists");

    // The LFSR never locks up at zero.
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("victim LFSR reached zero");

    // The victim slot lies inside the store.
    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |-> (IDX_W'(victim_reg) < IDX_W'(ENTRIES)
                                    || ENTRIES == (1 << IDX_W)))
        else $error("victim slot out of range");

    // At most one cell claims a hit.
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $onehot0(hit_vec))
        else $error("several cells report a hit");

    // A result never reports both a hit and an eviction.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> !(m_tuser[0] && m_tuser[1]))
        else $error("result flags hit and eviction together");

endmodule
